FILE: hdl/sabf_pkg.sv
`default_nettype none
package sabf_pkg;

  // Item kinds on the input channel.
  localparam logic [2:0] KIND_MIDDLE = 3'd0;
  localparam logic [2:0] KIND_FIRST  = 3'd1;
  localparam logic [2:0] KIND_LAST   = 3'd2;
  localparam logic [2:0] KIND_ONLY   = 3'd3;
  localparam logic [2:0] KIND_EMPTY  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BG_RED      = 3'd0;
  localparam logic [2:0] CFG_BG_GREEN    = 3'd1;
  localparam logic [2:0] CFG_BG_BLUE     = 3'd2;
  localparam logic [2:0] CFG_ALPHA_FLOOR = 3'd3;
  localparam logic [2:0] CFG_ALPHA_CAP   = 3'd4;
  localparam logic [2:0] CFG_TRANS_FLOOR = 3'd5;

  // Fixed-point constants.
  localparam logic [16:0] T_ONE     = 17'h10000;
  localparam logic [19:0] ACC_MAX   = 20'hFFFFF;
  localparam logic [15:0] SPLAT_CAP = 16'hFFFF;

  // Exponential table, round(65536 * exp(-16 * i / EXP_ENTRIES)).
  localparam int  EXP_ENTRIES = 1024;
  localparam int  EXP_AW      = $clog2(EXP_ENTRIES);
  localparam real EXP_STEP    = 16.0 / real'(EXP_ENTRIES);

  // Queue between the front and the back.
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  typedef logic [16:0] exp_tab_t [EXP_ENTRIES];

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    real      v;
    for (int i = 0; i < EXP_ENTRIES; i++) begin
      v = 65536.0 * $exp(-EXP_STEP * real'(i));
      tab[i] = 17'($rtoi(v + 0.5));
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  typedef struct packed {
    logic [15:0] bg_red;
    logic [15:0] bg_green;
    logic [15:0] bg_blue;
    logic [15:0] alpha_floor;
    logic [15:0] alpha_cap;
    logic [15:0] transmit_floor;
  } cfg_t;

  // One classified splat as the back part consumes it.
  typedef struct packed {
    logic [2:0]  kind;
    logic        skip;
    logic [15:0] alpha;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } blend_item_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [16:0] trans;
    logic [15:0] contrib;
  } pixel_result_t;

endpackage
`default_nettype wire

FILE: hdl/splat_alpha_blend_forward.sv
// Front-to-back alpha blending of depth-sorted Gaussian splats, one pixel at a time.
// Input channel: one splat per transfer (push/full), tagged first, middle, last,
// only splat, or pixel without splats; undefined kinds are dropped.
// Result channel: one blended pixel per last, only or empty item (empty/pop); the
// oldest result is on the out_ ports while empty is low.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index at once; write
// only while the block is idle.
// Path: a splat passes a 4-stage front pipeline (offsets, squares, conic
// products, table read) into an 8-entry queue; the back sequencer takes a
// skipped splat in its idle state and a blended one through its multiply and
// accumulate states, and emits each pixel's result in its emit state.
// The back sequencer takes no new splat until a blended one has finished its
// loop over transmittance (multiply, then accumulate).
// Reset: synchronous; afterwards the 1024-entry exponential table is filled,
// and full stays high while it fills.
// When the receiver stalls, two results wait in the output queue, then the back
// part holds, the middle queue fills and full rises.
`default_nettype none
module splat_alpha_blend_forward
  import sabf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [11:0]        in_pixel_x,
  input  wire logic [11:0]        in_pixel_y,
  input  wire logic signed [15:0] in_mean_x,
  input  wire logic signed [15:0] in_mean_y,
  input  wire logic signed [23:0] in_conic_a,
  input  wire logic signed [23:0] in_conic_b,
  input  wire logic signed [23:0] in_conic_c,
  input  wire logic [15:0]        in_opacity,
  input  wire logic [15:0]        in_color_red,
  input  wire logic [15:0]        in_color_green,
  input  wire logic [15:0]        in_color_blue,
  input  wire logic [2:0]         in_item_kind,
  output logic                    empty,
  input  wire logic               pop,
  output logic [15:0]             out_pixel_red,
  output logic [15:0]             out_pixel_green,
  output logic [15:0]             out_pixel_blue,
  output logic [16:0]             out_transmittance,
  output logic [15:0]             out_contributors,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);

  cfg_t          cfg_r;
  blend_item_t   f_item, q_head;
  logic          f_push, q_pop, q_empty, q_full, accept;
  logic [QAW:0]  q_count;
  pixel_result_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bg_red         <= 16'd65535;
      cfg_r.bg_green       <= 16'd65535;
      cfg_r.bg_blue        <= 16'd65535;
      cfg_r.alpha_floor    <= 16'd257;
      cfg_r.alpha_cap      <= 16'd64881;
      cfg_r.transmit_floor <= 16'd7;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BG_RED:      cfg_r.bg_red         <= cfg_wdata;
        CFG_BG_GREEN:    cfg_r.bg_green       <= cfg_wdata;
        CFG_BG_BLUE:     cfg_r.bg_blue        <= cfg_wdata;
        CFG_ALPHA_FLOOR: cfg_r.alpha_floor    <= cfg_wdata;
        CFG_ALPHA_CAP:   cfg_r.alpha_cap      <= cfg_wdata;
        CFG_TRANS_FLOOR: cfg_r.transmit_floor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  sabf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .pixel_x     (in_pixel_x),
    .pixel_y     (in_pixel_y),
    .mean_x      (in_mean_x),
    .mean_y      (in_mean_y),
    .conic_a     (in_conic_a),
    .conic_b     (in_conic_b),
    .conic_c     (in_conic_c),
    .opacity     (in_opacity),
    .color_red   (in_color_red),
    .color_green (in_color_green),
    .color_blue  (in_color_blue),
    .item_kind   (in_item_kind),
    .q_count     (q_count),
    .busy        (full),
    .push        (f_push),
    .item        (f_item)
  );

  sabf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_item),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  sabf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .result    (result)
  );

  assign out_pixel_red     = result.red;
  assign out_pixel_green   = result.green;
  assign out_pixel_blue    = result.blue;
  assign out_transmittance = result.trans;
  assign out_contributors  = result.contrib;

`ifndef SYNTHESIS
  // The credit check must keep the middle queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(f_push && q_full)) else $error("middle queue overflow");

  // A waiting result never reports transmittance above one.
  a_trans_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_transmittance <= T_ONE)) else $error("transmittance out of range");

  // After reset the table fill holds off input.
  a_fill_after_reset: assert property (@(posedge clk)
    !rst_n |=> full) else $error("input taken during table fill");
`endif

endmodule
`default_nettype wire

FILE: hdl/sabf_ram.sv
`default_nettype none
module sabf_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/sabf_front.sv
`default_nettype none
module sabf_front
  import sabf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               accept,
  input  wire logic [11:0]        pixel_x,
  input  wire logic [11:0]        pixel_y,
  input  wire logic signed [15:0] mean_x,
  input  wire logic signed [15:0] mean_y,
  input  wire logic signed [23:0] conic_a,
  input  wire logic signed [23:0] conic_b,
  input  wire logic signed [23:0] conic_c,
  input  wire logic [15:0]        opacity,
  input  wire logic [15:0]        color_red,
  input  wire logic [15:0]        color_green,
  input  wire logic [15:0]        color_blue,
  input  wire logic [2:0]         item_kind,
  input  wire logic [QAW:0]       q_count,
  output logic                    busy,
  output logic                    push,
  output blend_item_t             item
);

  logic [EXP_AW:0] fill_r;
  logic            filling;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic [2:0]        kind1_r, kind2_r, kind3_r, kind4_r;
  logic [15:0]       opa1_r, opa2_r, opa3_r, opa4_r;
  logic [47:0]       col1_r, col2_r, col3_r, col4_r;
  logic signed [17:0] dx1_r, dy1_r;
  logic signed [23:0] a1_r, b1_r, c1_r, a2_r, b2_r, c2_r;
  logic signed [35:0] dxx2_r, dyy2_r, dxy2_r;
  logic signed [59:0] pa3_r, pb3_r, pc3_r;
  logic              neg4_r, big4_r;

  logic signed [17:0] dx, dy;
  logic signed [61:0] q;
  logic [60:0]        x;
  logic [EXP_AW-1:0]  idx;
  logic [16:0]        g_raw, g;
  logic [32:0]        prod;
  logic [16:0]        alpha_raw;
  logic [15:0]        alpha;
  logic               kind_ok;
  logic [3:0]         inflight;

  // Table fill after reset, one entry a cycle.
  assign filling = ~fill_r[EXP_AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (filling) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  sabf_ram #(.WIDTH(17), .DEPTH(EXP_ENTRIES)) u_exp_ram (
    .clk   (clk),
    .we    (filling),
    .waddr (fill_r[EXP_AW-1:0]),
    .wdata (EXP_TAB[fill_r[EXP_AW-1:0]]),
    .raddr (idx),
    .rdata (g_raw)
  );

  // Credit check: every item in the pipe must find a queue slot.
  assign inflight = 4'(v1_r) + 4'(v2_r) + 4'(v3_r) + 4'(v4_r);
  assign busy = filling || ({1'b0, 4'(q_count)} + {1'b0, inflight} >= 5'(QDEPTH));

  assign kind_ok = item_kind inside {[KIND_MIDDLE:KIND_EMPTY]};

  // Stage 1: offsets from the pixel center.
  assign dx = {{2{mean_x[15]}}, mean_x} - $signed({2'b00, pixel_x, 4'b0000});
  assign dy = {{2{mean_y[15]}}, mean_y} - $signed({2'b00, pixel_y, 4'b0000});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept && kind_ok;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r   <= dx;
    dy1_r   <= dy;
    a1_r    <= conic_a;
    b1_r    <= conic_b;
    c1_r    <= conic_c;
    kind1_r <= item_kind;
    opa1_r  <= opacity;
    col1_r  <= {color_red, color_green, color_blue};
    // Stage 2: squares and cross term.
    dxx2_r  <= dx1_r * dx1_r;
    dyy2_r  <= dy1_r * dy1_r;
    dxy2_r  <= dx1_r * dy1_r;
    a2_r    <= a1_r;
    b2_r    <= b1_r;
    c2_r    <= c1_r;
    kind2_r <= kind1_r;
    opa2_r  <= opa1_r;
    col2_r  <= col1_r;
    // Stage 3: conic weights.
    pa3_r   <= a2_r * dxx2_r;
    pb3_r   <= b2_r * dxy2_r;
    pc3_r   <= c2_r * dyy2_r;
    kind3_r <= kind2_r;
    opa3_r  <= opa2_r;
    col3_r  <= col2_r;
    // Stage 4: sign and range of the quadratic form, table read in flight.
    neg4_r  <= q[61];
    big4_r  <= |x[60:28];
    kind4_r <= kind3_r;
    opa4_r  <= opa3_r;
    col4_r  <= col3_r;
  end

  // Quadratic form in Q.24 and the table index.
  assign q   = 62'(pa3_r) + 62'(pc3_r) + (62'(pb3_r) <<< 1);
  assign x   = 61'(q[61:1]);
  assign idx = x[27:28-EXP_AW];

  // Alpha from opacity and the exponential, then capped; below the floor the splat is skipped.
  assign g         = big4_r ? 17'd0 : g_raw;
  assign prod      = {17'd0, opa4_r} * {16'd0, g};
  assign alpha_raw = prod[32:16];
  assign alpha     = (alpha_raw > {1'b0, cfg.alpha_cap}) ? cfg.alpha_cap : alpha_raw[15:0];

  assign push       = v4_r;
  assign item.kind  = kind4_r;
  assign item.skip  = neg4_r || (alpha < cfg.alpha_floor);
  assign item.alpha = alpha;
  assign item.red   = col4_r[47:32];
  assign item.green = col4_r[31:16];
  assign item.blue  = col4_r[15:0];

endmodule
`default_nettype wire

FILE: hdl/sabf_queue.sv
`default_nettype none
module sabf_queue
  import sabf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire blend_item_t wdata,
  input  wire logic        pop,
  output blend_item_t      rdata,
  output logic             empty,
  output logic             full,
  output logic [QAW:0]     count
);

  blend_item_t      mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sabf_back.sv
`default_nettype none
module sabf_back
  import sabf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire blend_item_t head,
  input  wire logic        q_empty,
  output logic             q_pop,
  input  wire logic        out_pop,
  output logic             out_empty,
  output pixel_result_t    result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [16:0] trans_r, trans_nxt;
  logic [19:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [15:0] seen_r, seen_nxt, last_r, last_nxt;
  logic        done_r, done_nxt;
  logic        emit_r, emit_nxt;
  blend_item_t work_r, work_nxt;
  logic [16:0] test_r, ta_r;

  logic        clr, emit_k, count_en, done_eff;
  logic [15:0] seen_eff;
  logic [33:0] test_prod, ta_prod;
  logic [19:0] red_add, green_add, blue_add;
  pixel_result_t res;

  pixel_result_t ofifo_r [2];
  logic [1:0]    ocount_r;
  logic          ord_r, owr_r;
  logic          opush, opop;

  // Accumulate one channel with saturation.
  function automatic logic [19:0] acc_sat(input logic [19:0] acc, input logic [16:0] ta,
                                          input logic [15:0] col);
    logic [32:0] p;
    logic [20:0] s;
    p = {16'd0, ta} * {17'd0, col};
    s = {1'b0, acc} + {4'd0, p[32:16]};
    return (s > {1'b0, ACC_MAX}) ? ACC_MAX : s[19:0];
  endfunction

  // Background times transmittance plus color, saturated.
  function automatic logic [15:0] final_ch(input logic [15:0] bg, input logic [16:0] t,
                                           input logic [19:0] acc);
    logic [32:0] p;
    logic [20:0] s;
    p = {17'd0, bg} * {16'd0, t};
    s = {4'd0, p[32:16]} + {1'b0, acc};
    return (s > 21'd65535) ? 16'hFFFF : s[15:0];
  endfunction

  assign clr      = (head.kind == KIND_FIRST) || (head.kind == KIND_ONLY) ||
                    (head.kind == KIND_EMPTY);
  assign emit_k   = (head.kind == KIND_LAST) || (head.kind == KIND_ONLY) ||
                    (head.kind == KIND_EMPTY);
  assign done_eff = clr ? 1'b0 : done_r;
  assign seen_eff = clr ? 16'd0 : seen_r;
  assign count_en = (head.kind != KIND_EMPTY) && !done_eff && (seen_eff != SPLAT_CAP);

  assign test_prod = {17'd0, trans_r} * {17'd0, T_ONE - {1'b0, work_r.alpha}};
  assign ta_prod   = {17'd0, trans_r} * {18'd0, work_r.alpha};

  assign red_add   = acc_sat(red_r, ta_r, work_r.red);
  assign green_add = acc_sat(green_r, ta_r, work_r.green);
  assign blue_add  = acc_sat(blue_r, ta_r, work_r.blue);

  assign res.red     = final_ch(cfg.bg_red, trans_r, red_r);
  assign res.green   = final_ch(cfg.bg_green, trans_r, green_r);
  assign res.blue    = final_ch(cfg.bg_blue, trans_r, blue_r);
  assign res.trans   = trans_r;
  assign res.contrib = last_r;

  // Per-pixel sequencer: take, multiply, accumulate, emit.
  always_comb begin
    state_nxt = state_r;
    trans_nxt = trans_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    seen_nxt  = seen_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    emit_nxt  = emit_r;
    work_nxt  = work_r;
    q_pop     = 1'b0;
    opush     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          work_nxt = head;
          emit_nxt = emit_k;
          done_nxt = done_eff;
          seen_nxt = seen_eff + 16'(count_en);
          if (clr) begin
            trans_nxt = T_ONE;
            red_nxt   = '0;
            green_nxt = '0;
            blue_nxt  = '0;
            last_nxt  = '0;
          end
          if (count_en && !head.skip) begin
            state_nxt = ST_MUL;
          end else if (emit_k) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (test_r < {1'b0, cfg.transmit_floor}) begin
          done_nxt = 1'b1;
        end else begin
          red_nxt   = red_add;
          green_nxt = green_add;
          blue_nxt  = blue_add;
          trans_nxt = test_r;
          last_nxt  = seen_r;
        end
        state_nxt = emit_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (ocount_r != 2'd2) begin
          opush     = 1'b1;
          trans_nxt = T_ONE;
          red_nxt   = '0;
          green_nxt = '0;
          blue_nxt  = '0;
          seen_nxt  = '0;
          last_nxt  = '0;
          done_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      trans_r <= T_ONE;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      seen_r  <= '0;
      last_r  <= '0;
      done_r  <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      trans_r <= trans_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      seen_r  <= seen_nxt;
      last_r  <= last_nxt;
      done_r  <= done_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    test_r <= test_prod[32:16];
    ta_r   <= ta_prod[32:16];
  end

  // Two-entry result queue toward the receiver.
  assign out_empty = (ocount_r == 2'd0);
  assign opop      = out_pop && !out_empty;
  assign result    = ofifo_r[ord_r];

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo_r[owr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocount_r <= '0;
      ord_r    <= 1'b0;
      owr_r    <= 1'b0;
    end else begin
      if (opush) begin
        owr_r <= ~owr_r;
      end
      if (opop) begin
        ord_r <= ~ord_r;
      end
      ocount_r <= ocount_r + 2'(opush) - 2'(opop);
    end
  end

endmodule
`default_nettype wire
